>>> rtl/elsp_pkg.sv
package elsp_pkg;

   localparam int HOLD_MAX = 64;
   localparam int HOLD_AW = (HOLD_MAX > 1) ? $clog2(HOLD_MAX) : 1;
   localparam int CNT_W = $clog2(HOLD_MAX + 1);

   localparam int CFG_W = 7;
   localparam logic [CFG_W-1:0] GIVE_UP_RESET = 7'd64;

   typedef struct packed {
      logic accept;
      logic drain_emit;
      logic tail_emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic start_drain;
      logic start_tail;
      logic drain_done;
      logic tail_pending;
   } status_type;

endpackage

>>> rtl/escape_label_stripper_core.sv
// Channel  Handshake              Payload
// req      req_valid / req_stall  req_data_byte[7:0]
// rsp      rsp_valid / rsp_stall  rsp_out_byte[7:0], rsp_out_kind[1:0], rsp_last_of_run
// csr      csr_valid / csr_ready  csr_give_up_length[6:0]
//
// A byte that passes straight through or is only held is accepted at one per cycle
// while the output register is free; a passed byte goes out through that register.
// A release or label completion then drains the hold memory at one item per cycle
// from its registered read port while the output is not stalled, then emits any
// trailing item; new input is stalled until both are finished.
// Reset is synchronous and clears the match state, hold count and output valid.
// Input stalls whenever the output register is full and not being taken.
module escape_label_stripper_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic [1:0]                 rsp_out_kind,
   output logic                       rsp_last_of_run,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [elsp_pkg::CFG_W-1:0] csr_give_up_length
);

   elsp_pkg::cmd_type    cmd;
   elsp_pkg::status_type status;

   assign csr_ready = 1'b1;

   elsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   elsp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_last_of_run    (rsp_last_of_run),
      .csr_valid          (csr_valid),
      .csr_give_up_length (csr_give_up_length)
   );

endmodule

>>> rtl/elsp_ctrl.sv
module elsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  elsp_pkg::status_type status,
   output elsp_pkg::cmd_type    cmd
);

   localparam logic [1:0] ST_ACCEPT = 2'd0;
   localparam logic [1:0] ST_DRAIN  = 2'd1;
   localparam logic [1:0] ST_TAIL   = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.accept     = 1'b0;
      cmd.drain_emit = 1'b0;
      cmd.tail_emit  = 1'b0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_ACCEPT: begin
            req_stall  = !status.out_free;
            cmd.accept = req_valid && status.out_free;
            if (cmd.accept) begin
               if (status.start_drain) begin
                  state_in = ST_DRAIN;
               end else if (status.start_tail) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.drain_emit = 1'b1;
               if (status.drain_done) begin
                  state_in = status.tail_pending ? ST_TAIL : ST_ACCEPT;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.tail_emit = 1'b1;
               state_in      = ST_ACCEPT;
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/elsp_datapath.sv
module elsp_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  elsp_pkg::cmd_type                 cmd,
   output elsp_pkg::status_type              status,
   input  logic [7:0]                        req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_out_byte,
   output logic [1:0]                        rsp_out_kind,
   output logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   input  logic [elsp_pkg::CFG_W-1:0]        csr_give_up_length
);

   localparam int CW = elsp_pkg::CNT_W;
   localparam int AW = elsp_pkg::HOLD_AW;
   localparam int LIM_W = (CW > elsp_pkg::CFG_W) ? CW : elsp_pkg::CFG_W;

   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_BRACK = 8'h5D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ESC   = 2'd1;
   localparam logic [1:0] PH_BRACK = 2'd2;
   localparam logic [1:0] PH_TEXT  = 2'd3;

   localparam logic [1:0] KIND_PASS  = 2'd0;
   localparam logic [1:0] KIND_LABEL = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   localparam logic [LIM_W-1:0] LIM_LOW  = LIM_W'(4);
   localparam logic [LIM_W-1:0] LIM_HIGH = LIM_W'(elsp_pkg::HOLD_MAX);
   localparam logic [CW-1:0]    TEXT_START = CW'(3);

   logic [7:0] mem [elsp_pkg::HOLD_MAX];
   logic [7:0] mem_q_ff;

   logic [elsp_pkg::CFG_W-1:0] give_up_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] end_ff, end_in;
   logic [1:0]  drain_kind_ff, drain_kind_in;
   logic        tail_pending_ff, tail_pending_in;
   logic [7:0]  tail_byte_ff, tail_byte_in;
   logic [1:0]  tail_kind_ff, tail_kind_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [LIM_W-1:0] limit;
   logic [LIM_W-1:0] give_up_ext;
   logic [CW-1:0]    count_inc;
   logic [CW-1:0]    ptr_inc;

   logic            d_wr;
   logic [1:0]      d_phase;
   logic [CW-1:0]   d_count;
   logic            d_emit;
   logic            d_drain;
   logic [CW-1:0]   d_start;
   logic [CW-1:0]   d_end;
   logic [1:0]      d_kind;
   logic            d_tail;
   logic [7:0]      d_tail_byte;
   logic [1:0]      d_tail_kind;
   logic            d_hold;
   logic            d_fail;
   logic            d_nonempty;
   logic            load;

   assign give_up_ext = LIM_W'(give_up_ff);
   assign limit = (give_up_ext < LIM_LOW) ? LIM_LOW :
                  (give_up_ext > LIM_HIGH) ? LIM_HIGH : give_up_ext;
   assign count_inc = count_ff + CW'(1);
   assign ptr_inc   = ptr_ff + CW'(1);

   always_comb begin
      d_wr        = 1'b0;
      d_phase     = phase_ff;
      d_count     = count_ff;
      d_emit      = 1'b0;
      d_drain     = 1'b0;
      d_start     = '0;
      d_end       = count_ff;
      d_kind      = KIND_PASS;
      d_tail      = 1'b0;
      d_tail_byte = req_data_byte;
      d_tail_kind = KIND_PASS;
      d_hold      = 1'b0;
      d_fail      = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_data_byte == CH_ESC) begin
               d_hold = 1'b1;
            end else begin
               d_emit = 1'b1;
            end
         end
         PH_ESC: begin
            if (req_data_byte == CH_BRACK) begin
               d_hold = 1'b1;
            end else begin
               d_fail = 1'b1;
            end
         end
         PH_BRACK: begin
            if (req_data_byte == CH_SEMI) begin
               d_hold = 1'b1;
            end else begin
               d_fail = 1'b1;
            end
         end
         default: begin
            if (req_data_byte == CH_BEL) begin
               d_drain     = 1'b1;
               d_start     = TEXT_START;
               d_kind      = KIND_LABEL;
               d_tail      = 1'b1;
               d_tail_byte = 8'd0;
               d_tail_kind = KIND_DONE;
               d_phase     = PH_IDLE;
               d_count     = '0;
            end else if (req_data_byte < CH_SPACE) begin
               d_fail = 1'b1;
            end else begin
               d_hold = 1'b1;
            end
         end
      endcase
      if (d_fail) begin
         d_drain = 1'b1;
         d_tail  = 1'b1;
         d_phase = PH_IDLE;
         d_count = '0;
      end
      if (d_hold) begin
         d_wr    = 1'b1;
         d_count = count_inc;
         if (phase_ff != PH_TEXT) begin
            d_phase = phase_ff + 2'd1;
         end
         if (LIM_W'(count_inc) >= limit) begin
            d_drain = 1'b1;
            d_end   = count_inc;
            d_phase = PH_IDLE;
            d_count = '0;
         end
      end
   end

   assign d_nonempty = d_drain && (d_start != d_end);

   assign status.out_free     = !rsp_valid_ff || !rsp_stall;
   assign status.start_drain  = d_nonempty;
   assign status.start_tail   = d_tail && !d_nonempty;
   assign status.drain_done   = (ptr_inc == end_ff);
   assign status.tail_pending = tail_pending_ff;

   assign load = (cmd.accept && d_emit) || cmd.drain_emit || cmd.tail_emit;

   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      ptr_in          = ptr_ff;
      end_in          = end_ff;
      drain_kind_in   = drain_kind_ff;
      tail_pending_in = tail_pending_ff;
      tail_byte_in    = tail_byte_ff;
      tail_kind_in    = tail_kind_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_kind_in     = rsp_kind_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      if (cmd.accept) begin
         phase_in = d_phase;
         count_in = d_count;
         if (d_drain || d_tail) begin
            ptr_in          = d_start;
            end_in          = d_end;
            drain_kind_in   = d_kind;
            tail_pending_in = d_tail;
            tail_byte_in    = d_tail_byte;
            tail_kind_in    = d_tail_kind;
         end
         if (d_emit) begin
            rsp_byte_in = req_data_byte;
            rsp_kind_in = KIND_PASS;
            rsp_last_in = 1'b1;
         end
      end
      if (cmd.drain_emit) begin
         ptr_in      = ptr_inc;
         rsp_byte_in = mem_q_ff;
         rsp_kind_in = drain_kind_ff;
         rsp_last_in = status.drain_done && !tail_pending_ff;
      end
      if (cmd.tail_emit) begin
         tail_pending_in = 1'b0;
         rsp_byte_in     = tail_byte_ff;
         rsp_kind_in     = tail_kind_ff;
         rsp_last_in     = 1'b1;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && d_wr) begin
         mem[count_ff[AW-1:0]] <= req_data_byte;
      end
      mem_q_ff <= mem[ptr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         give_up_ff      <= elsp_pkg::GIVE_UP_RESET;
         phase_ff        <= PH_IDLE;
         count_ff        <= '0;
         tail_pending_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            give_up_ff <= csr_give_up_length;
         end
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         tail_pending_ff <= tail_pending_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff        <= ptr_in;
      end_ff        <= end_in;
      drain_kind_ff <= drain_kind_in;
      tail_byte_ff  <= tail_byte_in;
      tail_kind_ff  <= tail_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
